>>> design/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/fdmt_pkg.sv
// ----------------------------------------------------------------------------
// fdmt_pkg
// shared constants and types of the failure detector member table
// ----------------------------------------------------------------------------
package fdmt_pkg;
   localparam int TableDepth = 64;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_PING_RSP = 3'd2;
   localparam logic [2:0] CMD_PING_TMO = 3'd3;
   localparam logic [2:0] CMD_TICK = 3'd4;
   localparam logic [2:0] CMD_QUERY = 3'd5;

   localparam logic [1:0] ST_ALIVE = 2'd0;
   localparam logic [1:0] ST_SUSPECT = 2'd1;
   localparam logic [1:0] ST_DEAD = 2'd2;

   localparam logic [1:0] STS_OK = 2'd0;
   localparam logic [1:0] STS_FULL = 2'd1;
   localparam logic [1:0] STS_EXISTS = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   localparam logic [0:0] REG_MISS_THRESHOLD = 1'd0;
   localparam logic [0:0] REG_SUSPECT_TIMEOUT = 1'd1;

   // one table entry as held in memory
   typedef struct packed {
      logic [31:0] id;
      logic [1:0]  state;
      logic [47:0] seen_ms;
      logic [7:0]  misses;
   } entry_type;

   localparam int EntryW = $bits(entry_type);
endpackage

>>> design/failure_detector_member_table_top.sv
// ----------------------------------------------------------------------------
// failure_detector_member_table_top
// swim-style member table: add, remove, ping events, query and timeout tick
// ----------------------------------------------------------------------------
// A command beat is taken when req_start is high and req_busy is low; one
// command runs at a time. Each result beat shows for one cycle with rsp_valid
// and rsp_last marks the final result of a command. The receiver cannot
// stall, so results never wait and nothing is held back for it.
// Entries sit in one memory with one write port and a registered read port.
// The lookup reads one entry a cycle and stops at a hit or at the fill count.
// The command then acts, reading the hit entry again first when there is one.
// Remove then shifts later entries down. Tick reads the whole table, writing
// back members that turn dead; each tick result is held back in a register so
// the final one can carry last. The final result beat shows in the first cycle
// with busy low, where the next command can already be taken.
// Reset empties the table (the fill count clears) and loads the registers
// with threshold 3 and timeout 5000; there is no clearing pass.
// Registers are at byte address 0 (threshold) and 4 (timeout).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module failure_detector_member_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_node_id,
   input  logic [47:0] req_now_ms,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_subject_id,
   output logic        rsp_changed,
   output logic [1:0]  rsp_old_state,
   output logic [1:0]  rsp_new_state,
   output logic [1:0]  rsp_member_state,
   output logic [6:0]  rsp_live_count,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fdmt_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_ACT = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_TICK = 3'd4;

   logic [7:0]  thr;
   logic [31:0] tmo;

   fdmt_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready), .miss_threshold(thr), .suspect_timeout(tmo)
   );

   logic [2:0]      state_ff, state_in;
   logic [2:0]      cmd_ff, cmd_in;
   logic [31:0]     id_ff, id_in;
   logic [47:0]     now_ff, now_in;
   logic [CntW-1:0] count_ff, count_in;
   // address issued to memory this cycle and the one whose data now arrives
   logic [CntW-1:0] ra_ff, ra_in;
   logic [CntW-1:0] da_ff, da_in;
   logic            dv_ff, dv_in;
   logic            found_ff, found_in;
   logic [IdxW-1:0] hit_ff, hit_in;
   logic            emitted_ff, emitted_in;
   // tick result held back in a register
   logic [31:0]     pend_id_ff, pend_id_in;

   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   entry_type       wr_entry, rd_entry;
   logic [EntryW-1:0] rd_bits;

   fdmt_ram #(.Depth(TableDepth), .Width(EntryW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_entry),
      .rd_addr(ra_ff[IdxW-1:0]), .rd_data(rd_bits)
   );
   assign rd_entry = entry_type'(rd_bits);

   // result register
   logic        ov_ff, ov_in;
   logic [1:0]  osts_ff, osts_in;
   logic [31:0] osub_ff, osub_in;
   logic        ochg_ff, ochg_in;
   logic [1:0]  oold_ff, oold_in;
   logic [1:0]  onew_ff, onew_in;
   logic [1:0]  omst_ff, omst_in;
   logic [6:0]  ocnt_ff, ocnt_in;
   logic        olast_ff, olast_in;

   logic        accept;
   logic [47:0] elapsed;
   logic [7:0]  miss_inc;

   assign accept = req_start && (state_ff == S_IDLE);
   assign req_busy = (state_ff != S_IDLE);
   assign elapsed = now_ff - rd_entry.seen_ms;
   assign miss_inc = (rd_entry.misses == 8'hFF) ? 8'hFF : rd_entry.misses + 8'd1;

   // command sequencer
   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; id_in = id_ff; now_in = now_ff;
      count_in = count_ff; ra_in = ra_ff; da_in = da_ff; dv_in = 1'b0;
      found_in = found_ff; hit_in = hit_ff; emitted_in = emitted_ff;
      pend_id_in = pend_id_ff;
      wr_en = 1'b0; wr_addr = '0; wr_entry = rd_entry;
      ov_in = 1'b0; osts_in = STS_OK; osub_in = '0; ochg_in = 1'b0;
      oold_in = ST_ALIVE; onew_in = ST_ALIVE; omst_in = ST_ALIVE;
      ocnt_in = 7'(count_ff); olast_in = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd; id_in = req_node_id; now_in = req_now_ms;
               found_in = 1'b0; emitted_in = 1'b0; ra_in = '0;
               if (req_cmd == CMD_TICK) state_in = S_TICK;
               else state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue next read, compare returning data
            if (dv_ff && !found_ff && rd_entry.id == id_ff) begin
               found_in = 1'b1; hit_in = da_ff[IdxW-1:0];
            end
            if (!found_in && ra_ff < count_ff) begin
               dv_in = 1'b1; da_in = ra_ff; ra_in = ra_ff + 1'b1;
            end else if (!dv_ff || found_in) begin
               ra_in = {1'b0, hit_in};
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            // on a hit, wait for the re-read of the hit entry issued on entry, then act
            if (!dv_ff && found_ff) begin
               dv_in = 1'b1;
            end else begin
               state_in = S_IDLE;
               ov_in = 1'b1; osub_in = id_ff; omst_in = ST_DEAD;
               priority case (cmd_ff)
                  CMD_ADD: begin
                     if (count_ff >= CntW'(TableDepth)) osts_in = STS_FULL;
                     else if (found_ff) begin
                        osts_in = STS_EXISTS; omst_in = rd_entry.state;
                     end else begin
                        wr_en = 1'b1; wr_addr = count_ff[IdxW-1:0];
                        wr_entry.id = id_ff; wr_entry.state = ST_ALIVE;
                        wr_entry.seen_ms = now_ff; wr_entry.misses = '0;
                        count_in = count_ff + 1'b1; ocnt_in = 7'(count_in);
                        omst_in = ST_ALIVE;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!found_ff) osts_in = STS_NOT_FOUND;
                     else begin
                        ov_in = 1'b0; state_in = S_SHIFT;
                        ra_in = {1'b0, hit_ff} + 1'b1; da_in = {1'b0, hit_ff};
                     end
                  end
                  CMD_PING_RSP: begin
                     if (!found_ff) osts_in = STS_NOT_FOUND;
                     else begin
                        wr_en = 1'b1; wr_addr = hit_ff;
                        wr_entry.state = ST_ALIVE; wr_entry.misses = '0;
                        wr_entry.seen_ms = now_ff; omst_in = ST_ALIVE;
                        if (rd_entry.state != ST_ALIVE) begin
                           ochg_in = 1'b1; oold_in = rd_entry.state;
                           onew_in = ST_ALIVE;
                        end
                     end
                  end
                  CMD_PING_TMO: begin
                     if (!found_ff) osts_in = STS_NOT_FOUND;
                     else begin
                        wr_en = 1'b1; wr_addr = hit_ff; wr_entry.misses = miss_inc;
                        omst_in = rd_entry.state;
                        if (rd_entry.state == ST_ALIVE && miss_inc >= thr) begin
                           wr_entry.state = ST_SUSPECT; wr_entry.seen_ms = now_ff;
                           ochg_in = 1'b1; oold_in = ST_ALIVE;
                           onew_in = ST_SUSPECT; omst_in = ST_SUSPECT;
                        end
                     end
                  end
                  CMD_QUERY: begin
                     if (!found_ff) osts_in = STS_NOT_FOUND;
                     else omst_in = rd_entry.state;
                  end
                  default: begin
                     osub_in = '0; omst_in = ST_ALIVE;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // copy entry da-1 <- da, one per cycle once read data returns
            if (dv_ff) begin
               wr_en = 1'b1; wr_addr = da_ff[IdxW-1:0] - 1'b1;
            end
            if (ra_ff < count_ff) begin
               dv_in = 1'b1; da_in = ra_ff; ra_in = ra_ff + 1'b1;
            end else if (!dv_ff || da_ff + 1'b1 >= count_ff) begin
               if (!(dv_ff && ra_ff < count_ff)) begin
                  state_in = S_IDLE; count_in = count_ff - 1'b1;
                  ov_in = 1'b1; osub_in = id_ff; omst_in = ST_DEAD;
                  ocnt_in = 7'(count_in);
               end
            end
         end
         S_TICK: begin
            // walk every entry, turn timed-out suspects dead; each result is
            // held back in pend_id_ff so the final one goes out with last
            olast_in = 1'b0;
            if (dv_ff && rd_entry.state == ST_SUSPECT && elapsed >= {16'd0, tmo}) begin
               wr_en = 1'b1; wr_addr = da_ff[IdxW-1:0]; wr_entry.state = ST_DEAD;
               ov_in = emitted_ff; pend_id_in = rd_entry.id; emitted_in = 1'b1;
            end
            if (ra_ff < count_ff) begin
               dv_in = 1'b1; da_in = ra_ff; ra_in = ra_ff + 1'b1;
            end else if (!dv_ff) begin
               // all data seen: held result or the no-change beat is final
               state_in = S_IDLE; ov_in = 1'b1; olast_in = 1'b1;
            end
            if (emitted_ff) begin
               osub_in = pend_id_ff; ochg_in = 1'b1; oold_in = ST_SUSPECT;
               onew_in = ST_DEAD; omst_in = ST_DEAD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; dv_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; dv_ff <= dv_in; ov_ff <= ov_in;
      end
      cmd_ff <= cmd_in; id_ff <= id_in; now_ff <= now_in; ra_ff <= ra_in;
      da_ff <= da_in; found_ff <= found_in; hit_ff <= hit_in;
      emitted_ff <= emitted_in; pend_id_ff <= pend_id_in;
      osts_ff <= osts_in; osub_ff <= osub_in; ochg_ff <= ochg_in;
      oold_ff <= oold_in; onew_ff <= onew_in; omst_ff <= omst_in;
      ocnt_ff <= ocnt_in; olast_ff <= olast_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_status = osts_ff;
   assign rsp_subject_id = osub_ff;
   assign rsp_changed = ochg_ff;
   assign rsp_old_state = oold_ff;
   assign rsp_new_state = onew_ff;
   assign rsp_member_state = omst_ff;
   assign rsp_live_count = ocnt_ff;
   assign rsp_last = olast_ff;

   // checks
   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= CntW'(TableDepth))
   `ASSERT_NEXT(a_last_idle, clock, reset, ov_in && olast_in, state_ff == S_IDLE)
   `ASSERT_IMPLIES(a_busy_no_rsp_idle, clock, reset, rsp_valid && !rsp_last, req_busy)
endmodule

>>> design/fdmt_ram.sv
// ----------------------------------------------------------------------------
// fdmt_ram
// single-port-write, single-port-read entry memory, registered read data
// ----------------------------------------------------------------------------
module fdmt_ram #(
   parameter int Depth = 64,
   parameter int Width = 90
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/fdmt_csr.sv
// ----------------------------------------------------------------------------
// fdmt_csr
// apb register file holding the miss threshold and suspect timeout
// ----------------------------------------------------------------------------
module fdmt_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  miss_threshold,
   output logic [31:0] suspect_timeout
);
   import fdmt_pkg::*;

   logic [7:0]  thr_ff;
   logic [31:0] tmo_ff;
   logic        wr_beat;
   logic [0:0]  reg_sel;

   assign pready = 1'b1;
   assign wr_beat = psel & penable & pwrite;
   assign reg_sel = paddr[2:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 8'd3;
         tmo_ff <= 32'd5000;
      end else if (wr_beat) begin
         if (reg_sel == REG_MISS_THRESHOLD) thr_ff <= pwdata[7:0];
         else tmo_ff <= pwdata;
      end
   end

   // read mux
   always_comb begin
      if (reg_sel == REG_MISS_THRESHOLD) prdata = {24'd0, thr_ff};
      else prdata = tmo_ff;
   end

   assign miss_threshold = thr_ff;
   assign suspect_timeout = tmo_ff;
endmodule

>>> tb/failure_detector_member_table_top_tb.sv
// ----------------------------------------------------------------------------
// failure_detector_member_table_top_tb
// self-checking bench: directed table, a full-table pass, then random command mix, each result
// beat checked field by field against an in-bench membership table model
// ----------------------------------------------------------------------------
module failure_detector_member_table_top_tb;
   import fdmt_pkg::*;

   localparam int WatchLimit = 20000;
   localparam int NumRandom = 50;
   localparam logic [2:0] CMD_BAD = 3'd6;
   localparam logic [2:0] CMD_BAD_HI = 3'd7;
   localparam logic [2:0] ADDR_THRESH = 3'd0;
   localparam logic [2:0] ADDR_TMO = 3'd4;

   // one expected result beat
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] subject_id;
      logic        changed;
      logic [1:0]  prev_state;
      logic [1:0]  next_state;
      logic [1:0]  member_state;
      logic [6:0]  live_count;
      logic        last;
   } result_beat_type;

   // one directed row; has_exp marks rows with a typed-in answer
   typedef struct {
      logic [2:0]      cmd;
      logic [31:0]     id;
      logic [47:0]     now;
      bit              has_exp;
      result_beat_type exp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_start = 1'b0;
   logic        req_busy;
   logic [2:0]  req_cmd = '0;
   logic [31:0] req_node_id = '0;
   logic [47:0] req_now_ms = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_subject_id;
   logic        rsp_changed;
   logic [1:0]  rsp_old_state;
   logic [1:0]  rsp_new_state;
   logic [1:0]  rsp_member_state;
   logic [6:0]  rsp_live_count;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   failure_detector_member_table_top dut (.*);

   always #6 clock = ~clock;

   // model copy of the member table
   logic [31:0] mdl_id[TableDepth];
   logic [1:0]  mdl_state[TableDepth];
   logic [47:0] mdl_seen[TableDepth];
   logic [7:0]  mdl_miss[TableDepth];
   int          mdl_count;
   logic [7:0]  mdl_thresh;
   logic [31:0] mdl_tmo;

   result_beat_type pending_results[$];
   int errors = 0;
   int beats_seen = 0;
   int idle_cycles = 0;
   int state_changes = 0;

   function automatic int lookup_member(logic [31:0] id);
      for (int i = 0; i < mdl_count; i++)
         if (mdl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic result_beat_type mk(logic [1:0] sts, logic [31:0] subj, logic chg,
                                          logic [1:0] os, logic [1:0] ns, logic [1:0] ms);
      result_beat_type r;
      r = '0;
      r.status = sts; r.subject_id = subj; r.changed = chg;
      r.prev_state = os; r.next_state = ns; r.member_state = ms;
      return r;
   endfunction

   // advance the membership model by one command, queue its results
   task automatic predict_membership(logic [2:0] cmd, logic [31:0] id, logic [47:0] now);
      result_beat_type outs[$];
      int k;
      logic [1:0] old;
      logic [47:0] el;
      k = lookup_member(id);
      case (cmd)
         CMD_ADD: begin
            if (mdl_count >= TableDepth)
               outs.push_back(mk(STS_FULL, id, 1'b0, '0, '0, ST_DEAD));
            else if (k >= 0)
               outs.push_back(mk(STS_EXISTS, id, 1'b0, '0, '0, mdl_state[k]));
            else begin
               mdl_id[mdl_count] = id; mdl_state[mdl_count] = ST_ALIVE;
               mdl_seen[mdl_count] = now; mdl_miss[mdl_count] = '0;
               mdl_count++;
               outs.push_back(mk(STS_OK, id, 1'b0, '0, '0, ST_ALIVE));
            end
         end
         CMD_REMOVE: begin
            if (k < 0) outs.push_back(mk(STS_NOT_FOUND, id, 1'b0, '0, '0, ST_DEAD));
            else begin
               for (int j = k; j + 1 < mdl_count; j++) begin
                  mdl_id[j] = mdl_id[j+1]; mdl_state[j] = mdl_state[j+1];
                  mdl_seen[j] = mdl_seen[j+1]; mdl_miss[j] = mdl_miss[j+1];
               end
               mdl_count--;
               outs.push_back(mk(STS_OK, id, 1'b0, '0, '0, ST_DEAD));
            end
         end
         CMD_PING_RSP: begin
            if (k < 0) outs.push_back(mk(STS_NOT_FOUND, id, 1'b0, '0, '0, ST_DEAD));
            else begin
               old = mdl_state[k];
               mdl_state[k] = ST_ALIVE; mdl_miss[k] = '0; mdl_seen[k] = now;
               if (old != ST_ALIVE)
                  outs.push_back(mk(STS_OK, id, 1'b1, old, ST_ALIVE, ST_ALIVE));
               else outs.push_back(mk(STS_OK, id, 1'b0, '0, '0, ST_ALIVE));
            end
         end
         CMD_PING_TMO: begin
            if (k < 0) outs.push_back(mk(STS_NOT_FOUND, id, 1'b0, '0, '0, ST_DEAD));
            else begin
               if (mdl_miss[k] != 8'hff) mdl_miss[k]++;
               if (mdl_state[k] == ST_ALIVE && mdl_miss[k] >= mdl_thresh) begin
                  mdl_state[k] = ST_SUSPECT; mdl_seen[k] = now;
                  outs.push_back(mk(STS_OK, id, 1'b1, ST_ALIVE, ST_SUSPECT, ST_SUSPECT));
               end else outs.push_back(mk(STS_OK, id, 1'b0, '0, '0, mdl_state[k]));
            end
         end
         CMD_TICK: begin
            for (int i = 0; i < mdl_count; i++)
               if (mdl_state[i] == ST_SUSPECT) begin
                  el = now - mdl_seen[i];
                  if (el >= {16'd0, mdl_tmo}) begin
                     mdl_state[i] = ST_DEAD;
                     outs.push_back(mk(STS_OK, mdl_id[i], 1'b1, ST_SUSPECT, ST_DEAD,
                                       ST_DEAD));
                  end
               end
            if (outs.size() == 0) outs.push_back(mk(STS_OK, '0, 1'b0, '0, '0, '0));
         end
         CMD_QUERY: begin
            if (k < 0) outs.push_back(mk(STS_NOT_FOUND, id, 1'b0, '0, '0, ST_DEAD));
            else outs.push_back(mk(STS_OK, id, 1'b0, '0, '0, mdl_state[k]));
         end
         default: outs.push_back(mk(STS_OK, '0, 1'b0, '0, '0, '0));
      endcase
      foreach (outs[i]) begin
         outs[i].live_count = 7'(mdl_count);
         outs[i].last = (i == outs.size() - 1);
         if (outs[i].changed) state_changes++;
         pending_results.push_back(outs[i]);
      end
   endtask

   // check every result beat against the oldest expectation
   always @(posedge clock) begin
      result_beat_type got, want;
      if (!reset && rsp_valid) begin
         beats_seen++;
         got = {rsp_status, rsp_subject_id, rsp_changed, rsp_old_state, rsp_new_state,
                rsp_member_state, rsp_live_count, rsp_last};
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat %h", $time, got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            end
         end
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_start && !req_busy) || rsp_valid || (psel && penable && pwrite && pready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("failure_detector_member_table_top_tb failed");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_THRESH) mdl_thresh = data[7:0];
      else mdl_tmo = data;
      @(posedge clock);
   endtask

   // send one command beat after a random gap; start stays high past the
   // accepting edge unless a gap follows
   task automatic send_cmd(logic [2:0] cmd, logic [31:0] id, logic [47:0] now);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_start <= 1'b1; req_cmd <= cmd; req_node_id <= id; req_now_ms <= now;
      do @(posedge clock); while (req_busy);
      predict_membership(cmd, id, now);
   endtask

   task automatic drain_results();
      req_start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   stim_row_type directed[$];

   task automatic row(logic [2:0] c, logic [31:0] id, logic [47:0] n, bit he,
                      result_beat_type e);
      stim_row_type r;
      r.cmd = c; r.id = id; r.now = n; r.has_exp = he; r.exp = e;
      directed.push_back(r);
   endtask

   initial begin
      logic [47:0] clk_ms;
      logic [31:0] ids[8];
      logic [2:0] c;
      int pick;
      result_beat_type typed, m;
      mdl_count = 0; mdl_thresh = 8'd3; mdl_tmo = 32'd5000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: typed answers where they are obvious
      row(CMD_QUERY, 32'hffffffff, 48'd0, 1,
          mk(STS_NOT_FOUND, 32'hffffffff, 1'b0, '0, '0, ST_DEAD));
      row(CMD_TICK, 32'h0, 48'hffffffffffff, 1, mk(STS_OK, '0, 1'b0, '0, '0, '0));
      row(CMD_REMOVE, 32'h5, 48'd0, 1, mk(STS_NOT_FOUND, 32'h5, 1'b0, '0, '0, ST_DEAD));
      row(CMD_PING_RSP, 32'h5, 48'd0, 1, mk(STS_NOT_FOUND, 32'h5, 1'b0, '0, '0, ST_DEAD));
      row(CMD_PING_TMO, 32'h5, 48'd0, 1, mk(STS_NOT_FOUND, 32'h5, 1'b0, '0, '0, ST_DEAD));
      row(CMD_ADD, 32'h0, 48'hfffffffffff0, 0, '0);
      row(CMD_ADD, 32'hffffffff, 48'd0, 0, '0);
      row(CMD_ADD, 32'h0, 48'd1, 0, '0);
      row(CMD_PING_TMO, 32'h0, 48'hfffffffffff0, 0, '0);
      row(CMD_PING_TMO, 32'h0, 48'hfffffffffff0, 0, '0);
      row(CMD_PING_TMO, 32'h0, 48'hfffffffffff8, 0, '0);
      row(CMD_TICK, 32'h0, 48'd4000, 0, '0);
      row(CMD_TICK, 32'h0, 48'd5000, 0, '0);
      row(CMD_PING_RSP, 32'h0, 48'd6000, 0, '0);
      row(CMD_PING_RSP, 32'h0, 48'd6001, 0, '0);
      row(CMD_QUERY, 32'hffffffff, 48'd6002, 0, '0);
      row(CMD_REMOVE, 32'h0, 48'd6003, 0, '0);
      row(CMD_BAD, 32'h12345678, 48'd7, 0, '0);
      row(CMD_BAD_HI, 32'h1, 48'd7, 0, '0);
      row(CMD_REMOVE, 32'hffffffff, 48'd8, 0, '0);

      foreach (directed[i]) begin
         send_cmd(directed[i].cmd, directed[i].id, directed[i].now);
         if (directed[i].has_exp) begin
            // typed answer must agree with the model too
            m = pending_results[$];
            typed = directed[i].exp;
            typed.live_count = m.live_count;
            typed.last = 1'b1;
            if (m !== typed) begin
               errors++;
               $display("%0t: table row %0d expected %h model %h", $time, i, typed, m);
            end
         end
      end
      drain_results();

      // fill the table to full, overflow, turn every member dead in one tick,
      // then empty it
      for (int i = 0; i < TableDepth; i++) send_cmd(CMD_ADD, 32'(i * 7 + 1), 48'd10);
      send_cmd(CMD_ADD, 32'hdeadbeef, 48'd11);
      drain_results();
      csr_write(ADDR_THRESH, 32'd1);
      for (int i = 0; i < TableDepth; i++) send_cmd(CMD_PING_TMO, 32'(i * 7 + 1), 48'd20);
      send_cmd(CMD_TICK, 32'h0, 48'd20 + 48'd5000);
      drain_results();
      for (int i = 0; i < TableDepth; i++) send_cmd(CMD_REMOVE, 32'(i * 7 + 1), 48'd30);
      drain_results();

      // random phases over several register settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin csr_write(ADDR_THRESH, 32'd1); csr_write(ADDR_TMO, 32'd0); end
            1: begin csr_write(ADDR_THRESH, 32'd255); csr_write(ADDR_TMO, 32'hffffffff); end
            2: begin csr_write(ADDR_THRESH, 32'd2); csr_write(ADDR_TMO, 32'd100); end
            3: begin csr_write(ADDR_THRESH, 32'd0); csr_write(ADDR_TMO, $urandom()); end
            default: begin
               csr_write(ADDR_THRESH, $urandom_range(1, 6));
               csr_write(ADDR_TMO, $urandom_range(0, 3000));
            end
         endcase
         foreach (ids[i]) ids[i] = $urandom();
         clk_ms = {$urandom(), 16'(0)} | 48'($urandom());
         for (int n = 0; n < NumRandom / 5; n++) begin
            clk_ms = clk_ms + 48'($urandom_range(0, 1500));
            pick = $urandom_range(0, 19);
            if (pick < 4) c = CMD_ADD;
            else if (pick < 6) c = CMD_REMOVE;
            else if (pick < 9) c = CMD_PING_RSP;
            else if (pick < 14) c = CMD_PING_TMO;
            else if (pick < 17) c = CMD_TICK;
            else if (pick < 19) c = CMD_QUERY;
            else c = 3'($urandom_range(6, 7));
            send_cmd(c, ($urandom_range(0, 9) == 0) ? $urandom() : ids[$urandom_range(0, 7)],
                     ($urandom_range(0, 15) == 0) ? {$urandom(), 16'($urandom())} : clk_ms);
         end
         drain_results();
      end

      $display("covered directed table, full table overflow, a 64-member tick and %0d random commands",
               NumRandom);
      $display("result beats checked: %0d, state changes: %0d", beats_seen, state_changes);
      if (errors == 0 && pending_results.size() == 0)
         $display("failure_detector_member_table_top_tb passed");
      else
         $display("failure_detector_member_table_top_tb failed");
      $finish;
   end
endmodule
